// ===== src/sdfd_pkg.sv =====
// shared constants, types and helpers for the stereo damped feedback delay
package sdfd_pkg;

    // default sizes of the configurable storage and datapath
    localparam int LINE_DEPTH_DEF    = 32768;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int STEREO_OFFSET_DEF = 23;

    // fixed register field widths
    localparam int DELAY_W   = 15;
    localparam int COEF_W    = 16;
    localparam int QC_W      = 17;
    localparam int FRAC_BITS = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [QC_W-1:0] Q_ONE = 17'd32768;

    // register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_DELAY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIX      = 2'd3;

    // register reset values
    localparam logic [DELAY_W-1:0] DELAY_RST    = 15'd11125;
    localparam logic [COEF_W-1:0]  DAMPING_RST  = 16'd16384;
    localparam logic [COEF_W-1:0]  FEEDBACK_RST = 16'd11469;
    localparam logic [COEF_W-1:0]  MIX_RST      = 16'd16384;

    // multiply-accumulate steps, left channel then right channel
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] MS_ECHO_L = 4'd0;
    localparam logic [STEP_W-1:0] MS_HOLD_L = 4'd1;
    localparam logic [STEP_W-1:0] MS_DRY_L  = 4'd2;
    localparam logic [STEP_W-1:0] MS_FB_L   = 4'd3;
    localparam logic [STEP_W-1:0] MS_MIXD_L = 4'd4;
    localparam logic [STEP_W-1:0] MS_MIXW_L = 4'd5;
    localparam logic [STEP_W-1:0] MS_ECHO_R = 4'd6;
    localparam logic [STEP_W-1:0] MS_HOLD_R = 4'd7;
    localparam logic [STEP_W-1:0] MS_DRY_R  = 4'd8;
    localparam logic [STEP_W-1:0] MS_FB_R   = 4'd9;
    localparam logic [STEP_W-1:0] MS_MIXD_R = 4'd10;
    localparam logic [STEP_W-1:0] MS_MIXW_R = 4'd11;
    localparam logic [STEP_W-1:0] MS_FIN    = 4'd12;

    // control to the shared multiply-accumulate unit
    typedef struct packed {
        logic en;
        logic clear;
    } mac_ctl_t;

    // sequencer control to the datapath
    typedef struct packed {
        logic              dly_en;
        logic              rd_en;
        logic              run;
        logic [STEP_W-1:0] step;
        mac_ctl_t          mac;
        logic              done;
    } ctrl_t;

    // coefficients above one act as one
    function automatic logic [QC_W-1:0] clamp_q(input logic [COEF_W-1:0] c);
        logic [QC_W-1:0] ce;
        ce = {1'b0, c};
        return (ce > Q_ONE) ? Q_ONE : ce;
    endfunction

endpackage

// ===== src/stereo_damped_feedback_delay.sv =====
// Stereo feedback delay with one-pole damping: each accepted item (one left and one
// right sample) reads each channel's delay line (right reads STEREO_OFFSET samples
// further back), lowpasses the echo, adds it with the feedback gain to the input,
// writes that wet value back and returns a dry/wet crossfade, all saturated. Each item
// passes through a delay clamp step, a memory read step and the twelve product steps of
// the single shared multiply-accumulate unit (six products per channel), then a
// finishing step that waits while a previous result is still not taken; a new item is
// accepted only once the block is back in idle. The
// delay lines read as zero until written: a fill count tracks written history, so
// there is no clearing pass after reset. Configuration writes are always accepted and
// should be made only while the block is idle.
module stereo_damped_feedback_delay
    import sdfd_pkg::*;
#(
    parameter int LINE_DEPTH    = LINE_DEPTH_DEF,
    parameter int SAMPLE_BITS   = SAMPLE_BITS_DEF,
    parameter int STEREO_OFFSET = STEREO_OFFSET_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [COEF_W-1:0]             cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic signed [SAMPLE_BITS-1:0] left_sample,
    input  logic signed [SAMPLE_BITS-1:0] right_sample,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] left_out,
    output logic signed [SAMPLE_BITS-1:0] right_out
);

    localparam int AW    = $clog2(LINE_DEPTH);
    localparam int DW    = AW + 1;
    localparam int CMP_W = (DW > DELAY_W + 1) ? DW : DELAY_W + 1;
    localparam int SW    = AW + 2;

    ctrl_t ctrl;

    logic [DELAY_W-1:0] delay_reg;
    logic [COEF_W-1:0]  damping_reg;
    logic [COEF_W-1:0]  feedback_reg;
    logic [COEF_W-1:0]  mix_reg;

    logic [AW-1:0] wi_reg;
    logic [DW-1:0] fill_reg;

    logic signed [SAMPLE_BITS-1:0] in_l_reg;
    logic signed [SAMPLE_BITS-1:0] in_r_reg;
    logic signed [SAMPLE_BITS-1:0] lp_l_reg;
    logic signed [SAMPLE_BITS-1:0] lp_r_reg;
    logic signed [SAMPLE_BITS-1:0] wet_l_reg;
    logic signed [SAMPLE_BITS-1:0] wet_r_reg;
    logic signed [SAMPLE_BITS-1:0] mix_l_reg;
    logic signed [SAMPLE_BITS-1:0] left_out_reg;
    logic signed [SAMPLE_BITS-1:0] right_out_reg;
    logic                          out_valid_reg;

    logic [DW-1:0] d_l_reg;
    logic [DW-1:0] d_r_reg;
    logic          hit_l_reg;
    logic          hit_r_reg;

    logic [CMP_W-1:0] raw_l;
    logic [CMP_W-1:0] raw_r;
    logic [DW-1:0]    d_l_next;
    logic [DW-1:0]    d_r_next;
    logic [SW-1:0]    sum_l;
    logic [SW-1:0]    sum_r;
    logic [AW-1:0]    raddr_l;
    logic [AW-1:0]    raddr_r;

    logic [SAMPLE_BITS-1:0]        rdata_l;
    logic [SAMPLE_BITS-1:0]        rdata_r;
    logic signed [SAMPLE_BITS-1:0] echo_l;
    logic signed [SAMPLE_BITS-1:0] echo_r;

    logic [QC_W-1:0] dc;
    logic [QC_W-1:0] fb;
    logic [QC_W-1:0] mx;

    logic signed [SAMPLE_BITS-1:0] mac_a;
    logic [QC_W-1:0]               mac_c;
    logic signed [SAMPLE_BITS-1:0] mac_res;

    logic in_acc;
    logic out_busy;

    assign in_acc   = in_valid && in_ready;
    assign out_busy = out_valid_reg && !out_ready;

    // configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg    <= DELAY_RST;
            damping_reg  <= DAMPING_RST;
            feedback_reg <= FEEDBACK_RST;
            mix_reg      <= MIX_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_DELAY:    delay_reg    <= cfg_data[DELAY_W-1:0];
                REG_DAMPING:  damping_reg  <= cfg_data;
                REG_FEEDBACK: feedback_reg <= cfg_data;
                REG_MIX:      mix_reg      <= cfg_data;
                default:      ;
            endcase
        end
    end

    assign dc = clamp_q(damping_reg);
    assign fb = clamp_q(feedback_reg);
    assign mx = clamp_q(mix_reg);

    sdfd_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .out_busy (out_busy),
        .ctrl     (ctrl)
    );

    // input sample capture
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            in_l_reg <= left_sample;
            in_r_reg <= right_sample;
        end
    end

    // effective delays, clamped to the line, and whether history reaches them
    assign raw_l    = CMP_W'(delay_reg);
    assign raw_r    = CMP_W'(delay_reg) + CMP_W'(STEREO_OFFSET);
    assign d_l_next = (raw_l > CMP_W'(LINE_DEPTH)) ? DW'(LINE_DEPTH) : raw_l[DW-1:0];
    assign d_r_next = (raw_r > CMP_W'(LINE_DEPTH)) ? DW'(LINE_DEPTH) : raw_r[DW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_l_reg   <= '0;
            d_r_reg   <= '0;
            hit_l_reg <= 1'b0;
            hit_r_reg <= 1'b0;
        end
        else if (ctrl.dly_en)
        begin
            d_l_reg   <= d_l_next;
            d_r_reg   <= d_r_next;
            hit_l_reg <= (d_l_next != '0) && (d_l_next <= fill_reg);
            hit_r_reg <= (d_r_next != '0) && (d_r_next <= fill_reg);
        end
    end

    // read addresses, wrapped into the line
    assign sum_l   = SW'(wi_reg) + SW'(LINE_DEPTH) - SW'(d_l_reg);
    assign sum_r   = SW'(wi_reg) + SW'(LINE_DEPTH) - SW'(d_r_reg);
    assign raddr_l = (sum_l >= SW'(LINE_DEPTH)) ? AW'(sum_l - SW'(LINE_DEPTH))
                                                : sum_l[AW-1:0];
    assign raddr_r = (sum_r >= SW'(LINE_DEPTH)) ? AW'(sum_r - SW'(LINE_DEPTH))
                                                : sum_r[AW-1:0];

    sdfd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line_l (
        .clk   (clk),
        .we    (ctrl.done),
        .waddr (wi_reg),
        .wdata (wet_l_reg),
        .re    (ctrl.rd_en),
        .raddr (raddr_l),
        .rdata (rdata_l)
    );

    sdfd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (LINE_DEPTH)
    ) u_line_r (
        .clk   (clk),
        .we    (ctrl.done),
        .waddr (wi_reg),
        .wdata (wet_r_reg),
        .re    (ctrl.rd_en),
        .raddr (raddr_r),
        .rdata (rdata_r)
    );

    // unwritten history and zero delay read silence
    assign echo_l = hit_l_reg ? $signed(rdata_l) : '0;
    assign echo_r = hit_r_reg ? $signed(rdata_r) : '0;

    // operand selection for the shared mac
    always_comb
    begin
        mac_a = '0;
        mac_c = '0;
        case (ctrl.step)
            MS_ECHO_L: begin mac_a = echo_l;    mac_c = Q_ONE - dc; end
            MS_HOLD_L: begin mac_a = lp_l_reg;  mac_c = dc;         end
            MS_DRY_L:  begin mac_a = in_l_reg;  mac_c = Q_ONE;      end
            MS_FB_L:   begin mac_a = lp_l_reg;  mac_c = fb;         end
            MS_MIXD_L: begin mac_a = in_l_reg;  mac_c = Q_ONE - mx; end
            MS_MIXW_L: begin mac_a = wet_l_reg; mac_c = mx;         end
            MS_ECHO_R: begin mac_a = echo_r;    mac_c = Q_ONE - dc; end
            MS_HOLD_R: begin mac_a = lp_r_reg;  mac_c = dc;         end
            MS_DRY_R:  begin mac_a = in_r_reg;  mac_c = Q_ONE;      end
            MS_FB_R:   begin mac_a = lp_r_reg;  mac_c = fb;         end
            MS_MIXD_R: begin mac_a = in_r_reg;  mac_c = Q_ONE - mx; end
            MS_MIXW_R: begin mac_a = wet_r_reg; mac_c = mx;         end
            default:   begin mac_a = '0;        mac_c = '0;         end
        endcase
    end

    sdfd_mac #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (ctrl.mac),
        .a      (mac_a),
        .c      (mac_c),
        .result (mac_res)
    );

    // lowpass state, captured when its sum completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lp_l_reg <= '0;
            lp_r_reg <= '0;
        end
        else if (ctrl.run)
        begin
            if (ctrl.step == MS_DRY_L)
            begin
                lp_l_reg <= mac_res;
            end
            if (ctrl.step == MS_DRY_R)
            begin
                lp_r_reg <= mac_res;
            end
        end
    end

    // wet values and the left mix
    always_ff @(posedge clk)
    begin
        if (ctrl.run)
        begin
            if (ctrl.step == MS_MIXD_L)
            begin
                wet_l_reg <= mac_res;
            end
            if (ctrl.step == MS_ECHO_R)
            begin
                mix_l_reg <= mac_res;
            end
            if (ctrl.step == MS_MIXD_R)
            begin
                wet_r_reg <= mac_res;
            end
        end
    end

    // write pointer and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wi_reg   <= '0;
            fill_reg <= '0;
        end
        else if (ctrl.done)
        begin
            wi_reg <= (wi_reg == AW'(LINE_DEPTH - 1)) ? '0 : wi_reg + AW'(1);
            if (fill_reg != DW'(LINE_DEPTH))
            begin
                fill_reg <= fill_reg + DW'(1);
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.done)
        begin
            left_out_reg  <= mix_l_reg;
            right_out_reg <= mac_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign left_out  = left_out_reg;
    assign right_out = right_out_reg;

`ifndef SYNTHESIS
    a_done_shows_result: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.done |=> out_valid)
        else $error("finished item not presented");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |-> !ctrl.done)
        else $error("pending result overwritten");

    a_ptr_moves_on_done: assert property (@(posedge clk) disable iff (!rst_n)
        !ctrl.done |=> $stable(wi_reg) && $stable(fill_reg))
        else $error("write pointer moved without a finished item");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= DW'(LINE_DEPTH))
        else $error("fill count beyond line depth");

    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.dly_en || ctrl.rd_en || ctrl.run) |-> !in_ready)
        else $error("input taken while an item is in work");
`endif

endmodule

// ===== src/sdfd_ram.sv =====
// generic single write port, single read port ram with registered read
module sdfd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/sdfd_mac.sv =====
// shared multiply-accumulate unit with q1.15 rounding and saturation
module sdfd_mac
    import sdfd_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  mac_ctl_t                      ctl,
    input  logic signed [SAMPLE_BITS-1:0] a,
    input  logic [QC_W-1:0]               c,
    output logic signed [SAMPLE_BITS-1:0] result
);

    localparam int ACC_W = SAMPLE_BITS + QC_W + 1;
    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);
    localparam logic signed [ACC_W-1:0] RND = ACC_W'(1 << (FRAC_BITS - 1));

    logic signed [ACC_W-1:0] prod;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-1:0] shifted;

    // one product per cycle while enabled, either starting or adding to the sum
    assign prod = ACC_W'(a) * ACC_W'($signed({1'b0, c}));

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.en)
        begin
            acc_next = ctl.clear ? prod : acc_reg + prod;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg <= '0;
        end
        else
        begin
            acc_reg <= acc_next;
        end
    end

    // round half up, drop the fraction, saturate to sample range
    assign rnd     = acc_reg + RND;
    assign shifted = rnd >>> FRAC_BITS;

    always_comb
    begin
        if (shifted > SAT_HI)
        begin
            result = SAT_HI[SAMPLE_BITS-1:0];
        end
        else if (shifted < SAT_LO)
        begin
            result = SAT_LO[SAMPLE_BITS-1:0];
        end
        else
        begin
            result = shifted[SAMPLE_BITS-1:0];
        end
    end

endmodule

// ===== src/sdfd_seq.sv =====
// sequencer stepping one item through delay lookup and the shared mac
module sdfd_seq
    import sdfd_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  logic  out_busy,
    output ctrl_t ctrl
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DLY  = 2'd1;
    localparam logic [1:0] ST_ADR  = 2'd2;
    localparam logic [1:0] ST_RUN  = 2'd3;

    logic [1:0]        state_reg;
    logic [1:0]        state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              fin;

    assign fin = (state_reg == ST_RUN) && (step_reg == MS_FIN);

    // next state and step
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_DLY;
                end
            end
            ST_DLY:
            begin
                state_next = ST_ADR;
            end
            ST_ADR:
            begin
                state_next = ST_RUN;
                step_next  = MS_ECHO_L;
            end
            ST_RUN:
            begin
                if (step_reg != MS_FIN)
                begin
                    step_next = step_reg + STEP_W'(1);
                end
                else if (!out_busy)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= MS_ECHO_L;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    // control outputs
    always_comb
    begin
        ctrl.dly_en    = (state_reg == ST_DLY);
        ctrl.rd_en     = (state_reg == ST_ADR);
        ctrl.run       = (state_reg == ST_RUN);
        ctrl.step      = step_reg;
        ctrl.mac.en    = (state_reg == ST_RUN) && (step_reg <= MS_MIXW_R);
        ctrl.mac.clear = (step_reg == MS_ECHO_L) || (step_reg == MS_DRY_L)
                      || (step_reg == MS_MIXD_L) || (step_reg == MS_ECHO_R)
                      || (step_reg == MS_DRY_R)  || (step_reg == MS_MIXD_R);
        ctrl.done      = fin && !out_busy;
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

// ===== tb/testbench.sv =====
// self-checking testbench for the stereo damped feedback delay
module testbench;
    import sdfd_pkg::*;

    localparam int     DEPTH         = 32768;
    localparam int     OFFSET        = 23;
    localparam longint UNITY         = 32768;
    localparam int     STALL_LIMIT   = 4000;
    localparam int     HOLD_OFF      = 20;
    localparam int     SETTLE_CYCLES = 40;
    localparam int     RAND_PHASES   = 10;
    localparam int     PHASE_ITEMS   = 103;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
    } pair_t;

    typedef struct {
        longint lp;
        longint wet;
        longint mixed;
    } chan_res_t;

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        cfg_valid    = 1'b0;
    logic                        cfg_ready;
    logic [CFG_IDX_W-1:0]        cfg_index    = REG_DELAY;
    logic [COEF_W-1:0]           cfg_data     = '0;
    logic                        in_valid     = 1'b0;
    logic                        in_ready;
    logic signed [15:0]          left_sample  = '0;
    logic signed [15:0]          right_sample = '0;
    logic                        out_valid;
    logic                        out_ready    = 1'b0;
    logic signed [15:0]          left_out;
    logic signed [15:0]          right_out;

    // stimulus and expected results
    pair_t pending_pairs[$];
    pair_t mix_expected[$];
    int    queued_total = 0;
    int    taken_count  = 0;
    int    mismatches   = 0;
    int    quiet_cycles = 0;
    int    idle_pct     = 14;

    // predictor copy of the block state and registers
    logic signed [15:0] left_hist  [DEPTH] = '{default: '0};
    logic signed [15:0] right_hist [DEPTH] = '{default: '0};
    int                 hist_pos    = 0;
    longint             left_lp     = 0;
    longint             right_lp    = 0;
    logic [DELAY_W-1:0] cur_delay    = DELAY_RST;
    logic [COEF_W-1:0]  cur_damping  = DAMPING_RST;
    logic [COEF_W-1:0]  cur_feedback = FEEDBACK_RST;
    logic [COEF_W-1:0]  cur_mix      = MIX_RST;

    stereo_damped_feedback_delay dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .left_sample  (left_sample),
        .right_sample (right_sample),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .left_out     (left_out),
        .right_out    (right_out)
    );

    // clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // round half up then floor shift by 15
    function automatic longint round_q15(input longint v);
        return (v + 64'sd16384) >>> 15;
    endfunction

    function automatic longint sat16(input longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // coefficients above one act as one
    function automatic longint coef_limit(input logic [COEF_W-1:0] c);
        if (c > 16'd32768)
            return UNITY;
        return longint'(c);
    endfunction

    // tap a delay line, zero delay is silence and long delays stop at the oldest entry
    function automatic longint read_hist(input logic is_right, input int d);
        int idx;
        if (d == 0)
            return 0;
        if (d > DEPTH)
            d = DEPTH;
        idx = (hist_pos + DEPTH - d) % DEPTH;
        if (is_right)
            return longint'(right_hist[idx]);
        return longint'(left_hist[idx]);
    endfunction

    // damping lowpass, feedback sum and dry/wet crossfade of one channel
    function automatic chan_res_t run_channel(input longint echo, input longint lp_prev,
                                              input longint dry);
        longint    dc;
        longint    fb;
        longint    mx;
        chan_res_t r;
        dc      = coef_limit(cur_damping);
        fb      = coef_limit(cur_feedback);
        mx      = coef_limit(cur_mix);
        r.lp    = sat16(round_q15(echo * (UNITY - dc) + lp_prev * dc));
        r.wet   = sat16(dry + round_q15(r.lp * fb));
        r.mixed = sat16(round_q15(dry * (UNITY - mx) + r.wet * mx));
        return r;
    endfunction

    // advance the predicted state by one stereo pair and queue the result
    task automatic predict_pair(input pair_t p);
        chan_res_t lres;
        chan_res_t rres;
        pair_t     res;
        int        dl;
        dl   = int'(cur_delay);
        lres = run_channel(read_hist(1'b0, dl), left_lp, longint'($signed(p.left)));
        rres = run_channel(read_hist(1'b1, dl + OFFSET), right_lp,
                           longint'($signed(p.right)));
        left_lp              = lres.lp;
        right_lp             = rres.lp;
        left_hist[hist_pos]  = lres.wet[15:0];
        right_hist[hist_pos] = rres.wet[15:0];
        hist_pos             = (hist_pos + 1) % DEPTH;
        res.left             = lres.mixed[15:0];
        res.right            = rres.mixed[15:0];
        mix_expected.push_back(res);
    endtask

    task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        case (idx)
            REG_DELAY:    cur_delay    = val[DELAY_W-1:0];
            REG_DAMPING:  cur_damping  = val;
            REG_FEEDBACK: cur_feedback = val;
            REG_MIX:      cur_mix      = val;
            default:      ;
        endcase
    endtask

    // called just after a rising edge, returns at the edge that took the write
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COEF_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        apply_reg(idx, val);
    endtask

    task automatic queue_pair(input logic signed [15:0] l, input logic signed [15:0] r);
        pair_t p;
        p.left  = l;
        p.right = r;
        pending_pairs.push_back(p);
        queued_total++;
    endtask

    // hold the sender until every result is back, then let the pipeline settle
    task automatic wait_drained();
        while (!(taken_count == queued_total && mix_expected.size() == 0))
            @(posedge clk);
        repeat (HOLD_OFF) @(posedge clk);
    endtask

    function automatic logic [COEF_W-1:0] rand_delay();
        logic [DELAY_W-1:0] d;
        case ($urandom_range(9))
            0:       d = '0;
            1:       d = DELAY_W'($urandom_range(32767));
            2:       d = DELAY_W'($urandom_range(32744, 32767));
            default: d = DELAY_W'($urandom_range(1, 120));
        endcase
        return {1'($urandom_range(1)), d};
    endfunction

    function automatic logic [COEF_W-1:0] rand_coef();
        case ($urandom_range(7))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'($urandom_range(32769, 65535));
            3:       return 16'($urandom);
            default: return 16'($urandom_range(32768));
        endcase
    endfunction

    function automatic logic signed [15:0] rand_sample();
        case ($urandom_range(9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3:    return 16'($urandom_range(511)) - 16'sd256;
            default: return 16'($urandom);
        endcase
    endfunction

    // input driver
    always @(posedge clk)
    begin : input_driver
        pair_t next_pair;
        pair_t taken_pair;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                taken_pair.left  = left_sample;
                taken_pair.right = right_sample;
                predict_pair(taken_pair);
                taken_count++;
            end
            if (!in_valid || in_ready)
            begin
                if (pending_pairs.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    next_pair    = pending_pairs.pop_front();
                    in_valid     <= 1'b1;
                    left_sample  <= next_pair.left;
                    right_sample <= next_pair.right;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor and receiver stalls
    always @(posedge clk)
    begin : result_monitor
        pair_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (mix_expected.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected item, expected none, actual left %0d right %0d",
                             $time, left_out, right_out);
                end
                else
                begin
                    want = mix_expected.pop_front();
                    if (left_out !== want.left)
                    begin
                        mismatches++;
                        $display("%0t: left_out expected %0d actual %0d",
                                 $time, want.left, left_out);
                    end
                    if (right_out !== want.right)
                    begin
                        mismatches++;
                        $display("%0t: right_out expected %0d actual %0d",
                                 $time, want.right, right_out);
                    end
                end
            end
            out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // watchdog on cycles without any handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
                quiet_cycles <= 0;
            else if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings, sample extremes
        queue_pair(16'sh7fff, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7fff);
        queue_pair(16'sd0, 16'sd0);
        queue_pair(-16'sd1, 16'sd1);
        queue_pair(16'sd16384, -16'sd16384);
        queue_pair(16'sh7fff, 16'sh7fff);
        wait_drained();

        // zero delay on the left reads silence, full wet output
        write_reg(REG_DELAY, 16'd0);
        write_reg(REG_DAMPING, 16'd0);
        write_reg(REG_FEEDBACK, 16'd32768);
        write_reg(REG_MIX, 16'd32768);
        cfg_valid <= 1'b0;
        queue_pair(16'sh7fff, 16'sh8000);
        queue_pair(16'sh8000, 16'sh7fff);
        queue_pair(16'sd12345, -16'sd12345);
        queue_pair(16'sd0, 16'sd0);
        wait_drained();

        // one sample delay at full feedback drives the wet sum into saturation
        write_reg(REG_DELAY, 16'd1);
        write_reg(REG_MIX, 16'd0);
        cfg_valid <= 1'b0;
        queue_pair(16'sh7fff, 16'sh7fff);
        queue_pair(16'sh7fff, 16'sh7fff);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sh8000, 16'sh8000);
        queue_pair(16'sd5, -16'sd5);
        wait_drained();

        // longest delay clamps on the right, coefficients above one act as one
        write_reg(REG_DELAY, 16'hffff);
        write_reg(REG_DAMPING, 16'hffff);
        write_reg(REG_FEEDBACK, 16'hffff);
        write_reg(REG_MIX, 16'hffff);
        cfg_valid <= 1'b0;
        queue_pair(16'sh7fff, 16'sh8000);
        queue_pair(16'sd300, -16'sd300);
        queue_pair(16'sh8000, 16'sh7fff);
        queue_pair(16'sd0, 16'sd0);
        wait_drained();

        // random settings, mostly short delays so echoes recirculate
        for (int ph = 0; ph < RAND_PHASES; ph++)
        begin
            idle_pct = (ph == 4) ? 0 : 14;
            write_reg(REG_DELAY, (ph == 0) ? 16'd32744 : rand_delay());
            write_reg(REG_DAMPING, rand_coef());
            write_reg(REG_FEEDBACK, rand_coef());
            write_reg(REG_MIX, rand_coef());
            cfg_valid <= 1'b0;
            for (int n = 0; n < PHASE_ITEMS; n++)
                queue_pair(rand_sample(), rand_sample());
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && mix_expected.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
